@@ design/sample_frame_ring_assembler_assert.svh @@
// ----------------------------------------------------------------------------
// Sample frame ring assembler assertion macros
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_FRAME_RING_ASSEMBLER_ASSERT_SVH
`define SAMPLE_FRAME_RING_ASSEMBLER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SFRA_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfra: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SFRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfra: next-cycle check failed");

`endif

@@ design/sfra_pkg.sv @@
// ----------------------------------------------------------------------------
// sfra_pkg
// Sizes, command codes and shared types of the sample frame ring assembler.
// ----------------------------------------------------------------------------
package sfra_pkg;

	localparam int SAMPLES_PER_FRAME = 200;
	localparam int FRAME_SLOTS       = 8;
	localparam int STORE_DEPTH       = SAMPLES_PER_FRAME * FRAME_SLOTS;

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int FILL_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
	// read position runs over samples plus three stamp words
	localparam int RIDX_W = $clog2(SAMPLES_PER_FRAME + 3);

	localparam int OUT_FIFO_DEPTH = 3;
	localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
	localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_PPS    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	typedef enum logic [2:0] {
		WSEL_NONE   = 3'd0,
		WSEL_SAMPLE = 3'd1,
		WSEL_PPS    = 3'd2,
		WSEL_TIMER  = 3'd3,
		WSEL_FLAG   = 3'd4
	} wsel_t;

	typedef struct packed {
		logic        flag;
		logic [15:0] timer;
		logic [15:0] pps;
	} stamp_t;

	typedef struct packed {
		logic  valid;
		wsel_t sel;
		logic  dropped;
		logic  data_ready;
	} s1_ctl_t;

	typedef struct packed {
		logic [15:0] word;
		logic        word_valid;
		logic        last_word;
		logic        data_ready;
		logic        frame_dropped;
	} res_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] next_base(input logic [ADDR_W-1:0] base,
			input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : base + ADDR_W'(SAMPLES_PER_FRAME);
	endfunction

endpackage

@@ design/sfra_ram.sv @@
// ----------------------------------------------------------------------------
// sfra_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/sfra_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfra_ctrl
// Ring pointers, fill and read positions, PPS tracking; drives the memory
// ports and the read-stage control.
// ----------------------------------------------------------------------------
`include "sample_frame_ring_assembler_assert.svh"

module sfra_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   cmd,
	input  logic signed [15:0]           sample,
	input  logic [15:0]                  timer_count,
	input  logic [15:0]                  capture_count,
	output logic                         smp_we,
	output logic [sfra_pkg::ADDR_W-1:0] smp_waddr,
	output logic [15:0]                  smp_wdata,
	output logic                         smp_re,
	output logic [sfra_pkg::ADDR_W-1:0] smp_raddr,
	output logic                         stp_we,
	output logic [sfra_pkg::SLOT_W-1:0] stp_waddr,
	output sfra_pkg::stamp_t             stp_wdata,
	output logic                         stp_re,
	output logic [sfra_pkg::SLOT_W-1:0] stp_raddr,
	output sfra_pkg::s1_ctl_t            ctl_s1
);

	logic [sfra_pkg::SLOT_W-1:0] write_slot_q, read_slot_q, ws_d, rs_d;
	logic [sfra_pkg::ADDR_W-1:0] write_base_q, read_base_q, wb_d, rb_d;
	logic [sfra_pkg::FILL_W-1:0] fill_idx_q, fill_d;
	logic [sfra_pkg::RIDX_W-1:0] read_idx_q, ridx_d;
	logic                        pps_pending_q, pend_d;
	logic [15:0]                 last_pps_q, lpps_d;
	logic                        fill_last, ring_full, nonempty, dropped;
	sfra_pkg::wsel_t             sel;

	assign fill_last = (fill_idx_q == sfra_pkg::FILL_W'(sfra_pkg::SAMPLES_PER_FRAME - 1));
	assign ring_full = (sfra_pkg::next_slot(write_slot_q) == read_slot_q);
	assign nonempty  = (read_slot_q != write_slot_q);

	assign smp_waddr = write_base_q + sfra_pkg::ADDR_W'(fill_idx_q);
	assign smp_wdata = $unsigned(sample);
	assign smp_raddr = read_base_q + sfra_pkg::ADDR_W'(read_idx_q);
	assign stp_waddr = write_slot_q;
	assign stp_raddr = read_slot_q;
	assign stp_wdata = '{flag: pps_pending_q, timer: timer_count, pps: last_pps_q};

	always_comb begin
		ws_d    = write_slot_q;
		rs_d    = read_slot_q;
		wb_d    = write_base_q;
		rb_d    = read_base_q;
		fill_d  = fill_idx_q;
		ridx_d  = read_idx_q;
		pend_d  = pps_pending_q;
		lpps_d  = last_pps_q;
		smp_we  = 1'b0;
		smp_re  = 1'b0;
		stp_we  = 1'b0;
		stp_re  = 1'b0;
		dropped = 1'b0;
		sel     = sfra_pkg::WSEL_NONE;
		if (accept) begin
			case (cmd)
				sfra_pkg::CMD_SAMPLE: begin
					smp_we = 1'b1;
					if (fill_last) begin
						fill_d = '0;
						if (ring_full) begin
							// frame is lost; pending PPS carries to the next kept frame
							dropped = 1'b1;
						end else begin
							stp_we = 1'b1;
							pend_d = 1'b0;
							ws_d   = sfra_pkg::next_slot(write_slot_q);
							wb_d   = sfra_pkg::next_base(write_base_q, write_slot_q);
						end
					end else begin
						fill_d = fill_idx_q + 1'b1;
					end
				end
				sfra_pkg::CMD_PPS: begin
					pend_d = 1'b1;
					lpps_d = capture_count;
				end
				sfra_pkg::CMD_READ: begin
					if (nonempty) begin
						stp_re = 1'b1;
						ridx_d = read_idx_q + 1'b1;
						if (read_idx_q < sfra_pkg::RIDX_W'(sfra_pkg::SAMPLES_PER_FRAME)) begin
							smp_re = 1'b1;
							sel    = sfra_pkg::WSEL_SAMPLE;
						end else if (read_idx_q ==
								sfra_pkg::RIDX_W'(sfra_pkg::SAMPLES_PER_FRAME)) begin
							sel = sfra_pkg::WSEL_PPS;
						end else if (read_idx_q ==
								sfra_pkg::RIDX_W'(sfra_pkg::SAMPLES_PER_FRAME + 1)) begin
							sel = sfra_pkg::WSEL_TIMER;
						end else begin
							sel    = sfra_pkg::WSEL_FLAG;
							ridx_d = '0;
							rs_d   = sfra_pkg::next_slot(read_slot_q);
							rb_d   = sfra_pkg::next_base(read_base_q, read_slot_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			read_slot_q   <= '0;
			write_base_q  <= '0;
			read_base_q   <= '0;
			fill_idx_q    <= '0;
			read_idx_q    <= '0;
			pps_pending_q <= 1'b0;
			last_pps_q    <= '0;
			ctl_s1        <= '0;
		end else begin
			write_slot_q      <= ws_d;
			read_slot_q       <= rs_d;
			write_base_q      <= wb_d;
			read_base_q       <= rb_d;
			fill_idx_q        <= fill_d;
			read_idx_q        <= ridx_d;
			pps_pending_q     <= pend_d;
			last_pps_q        <= lpps_d;
			ctl_s1.valid      <= accept;
			ctl_s1.sel        <= sel;
			ctl_s1.dropped    <= dropped;
			ctl_s1.data_ready <= (rs_d != ws_d);
		end
	end

	`SFRA_ASSERT_NEXT(a_drop_keeps_slot, dropped, write_slot_q == $past(write_slot_q))
	`SFRA_ASSERT_NEXT(a_stamp_clears_pps, stp_we, !pps_pending_q)
	`SFRA_ASSERT_IMPLY(a_fill_in_range, 1'b1,
		fill_idx_q < sfra_pkg::FILL_W'(sfra_pkg::SAMPLES_PER_FRAME))

endmodule

@@ design/sfra_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sfra_out_fifo
// Small register FIFO holding finished results until the receiver takes them.
// ----------------------------------------------------------------------------
`include "sample_frame_ring_assembler_assert.svh"

module sfra_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  sfra_pkg::res_t                  push_data,
	input  logic                            pop,
	output logic                            head_valid,
	output sfra_pkg::res_t                  head,
	output logic [sfra_pkg::OUT_CNT_W-1:0] count
);

	sfra_pkg::res_t                  mem_q [sfra_pkg::OUT_FIFO_DEPTH];
	logic [sfra_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sfra_pkg::OUT_CNT_W-1:0] count_q;

	function automatic logic [sfra_pkg::OUT_PTR_W-1:0] ptr_inc(
			input logic [sfra_pkg::OUT_PTR_W-1:0] p);
		return (p == sfra_pkg::OUT_PTR_W'(sfra_pkg::OUT_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SFRA_ASSERT_IMPLY(a_no_overflow, push,
		count_q < sfra_pkg::OUT_CNT_W'(sfra_pkg::OUT_FIFO_DEPTH))
	`SFRA_ASSERT_IMPLY(a_count_bound, 1'b1,
		count_q <= sfra_pkg::OUT_CNT_W'(sfra_pkg::OUT_FIFO_DEPTH))
	`SFRA_ASSERT_IMPLY(a_pop_nonempty, pop, count_q != '0)

endmodule

@@ design/sample_frame_ring_assembler.sv @@
// ----------------------------------------------------------------------------
// sample_frame_ring_assembler
// Packs ADC samples into frames in a slot ring and reads them back word by word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_ready carries cmd, sample, timer_count and
//   capture_count. cmd selects: store a sample, record a PPS capture, or read
//   the next word of the oldest finished frame.
//   Every accepted transaction gives exactly one result on result_valid /
//   result_ready: word, word_valid, last_word, data_ready, frame_dropped.
//   Path: an accepted transaction is first registered in the synchronous
//   sample/stamp memory read stage, then written into the output buffer,
//   whose head drives result_valid.
//   Throughput: one transaction per cycle while item_ready is high; each makes
//   at most one access to the sample memory and one to the stamp memory.
//   Reset: ring empty, fill and read positions at zero, PPS state cleared.
//   Memory contents are left as they are; no clearing pass is run.
//   Receiver stall: results collect in a three-entry output buffer;
//   item_ready drops once the buffer plus the memory read stage hold three.
// ----------------------------------------------------------------------------
module sample_frame_ring_assembler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] sample,
	input  logic [15:0]        timer_count,
	input  logic [15:0]        capture_count,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [15:0]        word,
	output logic               word_valid,
	output logic               last_word,
	output logic               data_ready,
	output logic               frame_dropped
);

	logic                            accept;
	logic                            smp_we, smp_re, stp_we, stp_re;
	logic [sfra_pkg::ADDR_W-1:0]    smp_waddr, smp_raddr;
	logic [15:0]                     smp_wdata, smp_rdata;
	logic [sfra_pkg::SLOT_W-1:0]    stp_waddr, stp_raddr;
	sfra_pkg::stamp_t                stp_wdata, stp_rdata;
	sfra_pkg::s1_ctl_t               ctl_s1;
	sfra_pkg::res_t                  res_s1, head;
	logic [sfra_pkg::OUT_CNT_W-1:0] fifo_cnt;

	// room check counts the item in the read stage, so ready is register-driven
	assign item_ready = ((sfra_pkg::OUT_CNT_W + 1)'(fifo_cnt) +
		(sfra_pkg::OUT_CNT_W + 1)'(ctl_s1.valid)) <
		(sfra_pkg::OUT_CNT_W + 1)'(sfra_pkg::OUT_FIFO_DEPTH);
	assign accept = item_valid && item_ready;

	sfra_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.sample        (sample),
		.timer_count   (timer_count),
		.capture_count (capture_count),
		.smp_we        (smp_we),
		.smp_waddr     (smp_waddr),
		.smp_wdata     (smp_wdata),
		.smp_re        (smp_re),
		.smp_raddr     (smp_raddr),
		.stp_we        (stp_we),
		.stp_waddr     (stp_waddr),
		.stp_wdata     (stp_wdata),
		.stp_re        (stp_re),
		.stp_raddr     (stp_raddr),
		.ctl_s1        (ctl_s1)
	);

	sfra_ram #(
		.WIDTH (16),
		.DEPTH (sfra_pkg::STORE_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (smp_waddr),
		.wdata (smp_wdata),
		.re    (smp_re),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	sfra_ram #(
		.WIDTH ($bits(sfra_pkg::stamp_t)),
		.DEPTH (sfra_pkg::FRAME_SLOTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stp_we),
		.waddr (stp_waddr),
		.wdata (stp_wdata),
		.re    (stp_re),
		.raddr (stp_raddr),
		.rdata (stp_rdata)
	);

	always_comb begin
		res_s1.word          = '0;
		res_s1.word_valid    = 1'b1;
		res_s1.last_word     = 1'b0;
		res_s1.data_ready    = ctl_s1.data_ready;
		res_s1.frame_dropped = ctl_s1.dropped;
		case (ctl_s1.sel)
			sfra_pkg::WSEL_SAMPLE: res_s1.word = smp_rdata;
			sfra_pkg::WSEL_PPS:    res_s1.word = stp_rdata.pps;
			sfra_pkg::WSEL_TIMER:  res_s1.word = stp_rdata.timer;
			sfra_pkg::WSEL_FLAG: begin
				res_s1.word      = {15'd0, stp_rdata.flag};
				res_s1.last_word = 1'b1;
			end
			default: res_s1.word_valid = 1'b0;
		endcase
	end

	sfra_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (ctl_s1.valid),
		.push_data  (res_s1),
		.pop        (result_valid && result_ready),
		.head_valid (result_valid),
		.head       (head),
		.count      (fifo_cnt)
	);

	assign word          = head.word;
	assign word_valid    = head.word_valid;
	assign last_word     = head.last_word;
	assign data_ready    = head.data_ready;
	assign frame_dropped = head.frame_dropped;

endmodule

@@ verif/sample_frame_ring_assembler_tb.sv @@
// ----------------------------------------------------------------------------
// sample_frame_ring_assembler_tb
// Drives sample, PPS, read and unused commands into the assembler, predicts
// every result from its own copy of the frame ring and checks each result
// field by field, in order. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_frame_ring_assembler_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [1:0]         cmd = sfra_pkg::CMD_SAMPLE;
	logic signed [15:0] sample = '0;
	logic [15:0]        timer_count = '0;
	logic [15:0]        capture_count = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [15:0]        word;
	logic               word_valid;
	logic               last_word;
	logic               data_ready;
	logic               frame_dropped;

	sample_frame_ring_assembler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.sample        (sample),
		.timer_count   (timer_count),
		.capture_count (capture_count),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.word          (word),
		.word_valid    (word_valid),
		.last_word     (last_word),
		.data_ready    (data_ready),
		.frame_dropped (frame_dropped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Ring image kept by the testbench
	// ------------------------------------------------------------------
	logic [15:0] ring_samples [sfra_pkg::STORE_DEPTH];
	logic [15:0] ring_pps     [sfra_pkg::FRAME_SLOTS];
	logic [15:0] ring_timer   [sfra_pkg::FRAME_SLOTS];
	logic        ring_flag    [sfra_pkg::FRAME_SLOTS];
	int          fill_slot = 0;
	int          oldest_slot = 0;
	int          fill_pos = 0;
	int          read_pos = 0;
	logic        pps_seen = 1'b0;
	logic [15:0] pps_capture = '0;

	sfra_pkg::res_t due_words [$];
	sfra_pkg::res_t oldest_due;
	int             mismatch_count = 0;
	int             burst_left = 0;

	function automatic int advance_slot(int s);
		return (s + 1 >= sfra_pkg::FRAME_SLOTS) ? 0 : s + 1;
	endfunction

	// Applies one transaction to the ring image and returns its result.
	function automatic sfra_pkg::res_t assemble_frame_word(logic [1:0] c, logic [15:0] s,
			logic [15:0] t, logic [15:0] p);
		sfra_pkg::res_t r;
		r = '0;
		case (c)
			sfra_pkg::CMD_SAMPLE: begin
				ring_samples[fill_slot * sfra_pkg::SAMPLES_PER_FRAME + fill_pos] = s;
				fill_pos++;
				if (fill_pos >= sfra_pkg::SAMPLES_PER_FRAME) begin
					fill_pos = 0;
					if (advance_slot(fill_slot) == oldest_slot) begin
						// ring full: frame lost, pending PPS carried over
						r.frame_dropped = 1'b1;
					end else begin
						ring_pps[fill_slot]   = pps_capture;
						ring_timer[fill_slot] = t;
						ring_flag[fill_slot]  = pps_seen;
						pps_seen  = 1'b0;
						fill_slot = advance_slot(fill_slot);
					end
				end
			end
			sfra_pkg::CMD_PPS: begin
				pps_seen    = 1'b1;
				pps_capture = p;
			end
			sfra_pkg::CMD_READ: begin
				if (oldest_slot != fill_slot) begin
					r.word_valid = 1'b1;
					if (read_pos < sfra_pkg::SAMPLES_PER_FRAME)
						r.word = ring_samples[oldest_slot * sfra_pkg::SAMPLES_PER_FRAME
							+ read_pos];
					else if (read_pos == sfra_pkg::SAMPLES_PER_FRAME)
						r.word = ring_pps[oldest_slot];
					else if (read_pos == sfra_pkg::SAMPLES_PER_FRAME + 1)
						r.word = ring_timer[oldest_slot];
					else begin
						r.word      = {15'd0, ring_flag[oldest_slot]};
						r.last_word = 1'b1;
					end
					if (r.last_word) begin
						read_pos    = 0;
						oldest_slot = advance_slot(oldest_slot);
					end else begin
						read_pos++;
					end
				end
			end
			default: ;
		endcase
		r.data_ready = (oldest_slot != fill_slot);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	task automatic send_item(input logic [1:0] c, input logic [15:0] s,
			input logic [15:0] t, input logic [15:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid    <= 1'b1;
		cmd           <= c;
		sample        <= s;
		timer_count   <= t;
		capture_count <= p;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		due_words.push_back(assemble_frame_word(c, s, t, p));
	endtask

	task automatic send_cmd(input logic [1:0] c);
		send_item(c, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic drain_ring();
		while (oldest_slot != fill_slot) send_cmd(sfra_pkg::CMD_READ);
		send_cmd(sfra_pkg::CMD_READ);
		send_cmd(sfra_pkg::CMD_READ);
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes every so often
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_phase_left = 0;

	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_mode       = $urandom_range(0, 3);
			stall_phase_left = $urandom_range(20, 150);
		end
		stall_phase_left--;
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= ($urandom_range(0, 5) == 0);
			default: result_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string fname, logic [15:0] exp_v,
			logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_words.size() == 0) begin
				$display("%0t: result with nothing expected, word %h", $time, word);
				mismatch_count++;
			end else begin
				oldest_due = due_words.pop_front();
				check_field("word", oldest_due.word, word);
				check_field("word_valid", 16'(oldest_due.word_valid), 16'(word_valid));
				check_field("last_word", 16'(oldest_due.last_word), 16'(last_word));
				check_field("data_ready", 16'(oldest_due.data_ready), 16'(data_ready));
				check_field("frame_dropped", 16'(oldest_due.frame_dropped),
					16'(frame_dropped));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reads on an empty ring, unused command, repeated PPS, field extremes
	task automatic test_idle_commands();
		send_item(sfra_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(sfra_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000);
		send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000);
		send_item(sfra_pkg::CMD_PPS, 16'h0000, 16'h0000, 16'hFFFF);
		send_item(sfra_pkg::CMD_PPS, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_item(sfra_pkg::CMD_SAMPLE, 16'h8000, 16'h0000, 16'hFFFF);
		send_item(sfra_pkg::CMD_SAMPLE, 16'h7FFF, 16'hFFFF, 16'h0000);
		send_item(sfra_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		send_item(sfra_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(sfra_pkg::CMD_READ, 16'h5555, 16'hAAAA, 16'h5555);
		send_item(sfra_pkg::CMD_PPS, 16'hAAAA, 16'h5555, 16'h1234);
		send_item(CMD_UNUSED, 16'h5555, 16'hAAAA, 16'hAAAA);
	endtask

	// one frame completed and read out whole, PPS arriving mid read-out
	task automatic test_single_frame();
		int i;
		while (fill_pos != sfra_pkg::SAMPLES_PER_FRAME - 1) send_cmd(sfra_pkg::CMD_SAMPLE);
		send_item(sfra_pkg::CMD_SAMPLE, 16'h8000, 16'hFFFF, 16'h0000);
		for (i = 0; i < sfra_pkg::SAMPLES_PER_FRAME + 3; i++) begin
			if (i == 50) send_item(sfra_pkg::CMD_PPS, 16'h0000, 16'h0000, 16'hBEEF);
			send_cmd(sfra_pkg::CMD_READ);
		end
		send_cmd(sfra_pkg::CMD_READ);
	endtask

	// mixed traffic in fill-heavy and read-heavy stretches
	task automatic test_random_traffic(input int n_items);
		int seg;
		int k;
		int r;
		bit fill_heavy;
		logic [1:0] c;
		while (n_items > 0) begin
			seg        = $urandom_range(40, 300);
			fill_heavy = 1'($urandom_range(0, 1));
			for (k = 0; k < seg && n_items > 0; k++) begin
				r = $urandom_range(0, 99);
				if (fill_heavy)
					c = (r < 88) ? sfra_pkg::CMD_SAMPLE : (r < 93) ? sfra_pkg::CMD_PPS :
						(r < 98) ? sfra_pkg::CMD_READ : CMD_UNUSED;
				else
					c = (r < 12) ? sfra_pkg::CMD_SAMPLE : (r < 16) ? sfra_pkg::CMD_PPS :
						(r < 97) ? sfra_pkg::CMD_READ : CMD_UNUSED;
				send_cmd(c);
				n_items--;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_idle_commands();
		test_single_frame();
		test_random_traffic(600);
		drain_ring();
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("sample_frame_ring_assembler verification clean");
		else
			$display("sample_frame_ring_assembler verification failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("sample_frame_ring_assembler verification failed");
		$finish;
	end

endmodule
